@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while reset is asserted (active low).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sil_pkg.sv @@
// ---------------------------------------------------------------------------
// sil_pkg
// Types, codes and constants shared by the sorted insert list unit.
// ---------------------------------------------------------------------------
package sil_pkg;

  localparam int DepthDefault = 16;
  localparam int KindW        = 2;
  localparam int ValW         = 8;
  localparam int StatusW      = 3;
  localparam int PosW         = 4;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_READOUT = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DROPPED  = 3'd1,
    STAT_ENTRY    = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [ValW-1:0]  entry_value;
    logic [PosW-1:0]  position;
    logic             last;
  } result_t;

endpackage

@@ hdl/sil_out_reg.sv @@
// ---------------------------------------------------------------------------
// sil_out_reg
// Output register for result words: takes a word whenever it is empty or
// being drained, holds it while the consumer stalls.
// ---------------------------------------------------------------------------
module sil_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sil_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             stall_i,
  output sil_pkg::result_t data_o
);

  logic             valid_q, valid_d;
  sil_pkg::result_t data_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    if (push_i) begin
      valid_d = 1'b1;
    end else if (stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/sorted_insert_list_unit.sv @@
// Result path by state: drop, clear and empty readout go from idle straight to
// the response state; an insert into 0 or 1 entries goes through place, else
// through a shift sweep that moves one entry per cycle, then place and response.
// Readout: first entry, then one entry per unstalled cycle, from the response
// register. One item at a time: the next is accepted in the cycle after the final
// word. Reset clears fill count and control state, not the table.
// ---------------------------------------------------------------------------
// sorted_insert_list_unit
// Ordered byte table in a synchronous memory: fixed head, descending tail,
// inserts by a backward read-compare-move sweep, readout one word per unstalled cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_insert_list_unit #(
  parameter int DEPTH = sil_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sil_pkg::KindW-1:0]   in_kind_i,
  input  logic [sil_pkg::ValW-1:0]    in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sil_pkg::StatusW-1:0] out_status_o,
  output logic [sil_pkg::ValW-1:0]    out_entry_value_o,
  output logic [sil_pkg::PosW-1:0]    out_position_o,
  output logic                        out_last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = sil_pkg::ValW;
  localparam int PW = sil_pkg::PosW;

  sil_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [VW-1:0]    val_q, val_d;
  sil_pkg::status_e resp_status_q, resp_status_d;

  logic [VW-1:0]    mem_q [DEPTH];
  logic [VW-1:0]    rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VW-1:0]    mem_wdata;

  logic             in_acc;
  logic             push, push_ok;
  sil_pkg::result_t push_data, out_data;
  logic             full, last_entry, move;

  assign in_stall_o = (state_q != sil_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (fill_q == CW'(DEPTH));
  assign last_entry = ((CW'(idx_q) + CW'(1)) == fill_q);
  assign move       = (rdata_q < val_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sil_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (sil_pkg::kind_e'(in_kind_i))
            sil_pkg::KIND_INSERT: begin
              if (full) begin
                state_d = sil_pkg::ST_RESP;
              end else if (fill_q < CW'(2)) begin
                state_d = sil_pkg::ST_PLACE;
              end else begin
                state_d = sil_pkg::ST_SHIFT;
              end
            end
            sil_pkg::KIND_READOUT: begin
              if (fill_q == '0) begin
                state_d = sil_pkg::ST_RESP;
              end else begin
                state_d = sil_pkg::ST_READ;
              end
            end
            sil_pkg::KIND_CLEAR: begin
              state_d = sil_pkg::ST_RESP;
            end
            default: begin
              state_d = sil_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sil_pkg::ST_SHIFT: begin
        if (!move || (idx_q == AW'(1))) begin
          state_d = sil_pkg::ST_PLACE;
        end
      end
      sil_pkg::ST_PLACE: begin
        state_d = sil_pkg::ST_RESP;
      end
      sil_pkg::ST_READ: begin
        if (push_ok && last_entry) begin
          state_d = sil_pkg::ST_IDLE;
        end
      end
      sil_pkg::ST_RESP: begin
        if (push_ok) begin
          state_d = sil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sil_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = idx_q + AW'(1);
    mem_wdata     = rdata_q;
    mem_re        = 1'b0;
    mem_raddr     = idx_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    val_d         = val_q;
    fill_d        = fill_q;
    resp_status_d = resp_status_q;
    push          = 1'b0;
    push_data     = '{status: resp_status_q, entry_value: '0,
                      position: PW'(pos_q), last: 1'b1};
    case (state_q)
      sil_pkg::ST_IDLE: begin
        if (in_acc) begin
          val_d = in_value_i;
          case (sil_pkg::kind_e'(in_kind_i))
            sil_pkg::KIND_INSERT: begin
              if (full) begin
                resp_status_d = sil_pkg::STAT_DROPPED;
                pos_d         = '0;
              end else if (fill_q == '0) begin
                pos_d = '0;
              end else if (fill_q == CW'(1)) begin
                pos_d = AW'(1);
              end else begin
                // start the sweep at the tail
                mem_re    = 1'b1;
                mem_raddr = AW'(fill_q - CW'(1));
                idx_d     = AW'(fill_q - CW'(1));
              end
            end
            sil_pkg::KIND_READOUT: begin
              if (fill_q == '0) begin
                resp_status_d = sil_pkg::STAT_EMPTY;
                pos_d         = '0;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
              end
            end
            sil_pkg::KIND_CLEAR: begin
              fill_d        = '0;
              resp_status_d = sil_pkg::STAT_CLEARED;
              pos_d         = '0;
            end
            default: begin
              fill_d = fill_q;
            end
          endcase
        end
      end
      sil_pkg::ST_SHIFT: begin
        if (move) begin
          // move the smaller entry one place down, fetch the one above
          mem_we = 1'b1;
          if (idx_q == AW'(1)) begin
            pos_d = AW'(1);
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q - AW'(1);
            idx_d     = idx_q - AW'(1);
          end
        end else begin
          pos_d = idx_q + AW'(1);
        end
      end
      sil_pkg::ST_PLACE: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_q;
        mem_wdata     = val_q;
        fill_d        = fill_q + CW'(1);
        resp_status_d = sil_pkg::STAT_INSERTED;
      end
      sil_pkg::ST_READ: begin
        push_data = '{status: sil_pkg::STAT_ENTRY, entry_value: rdata_q,
                      position: PW'(idx_q), last: last_entry};
        if (push_ok) begin
          push = 1'b1;
          if (!last_entry) begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end
        end
      end
      sil_pkg::ST_RESP: begin
        push = push_ok;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sil_pkg::ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    resp_status_q <= resp_status_d;
  end

  // Table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  sil_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (push_ok),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign out_status_o      = out_data.status;
  assign out_entry_value_o = out_data.entry_value;
  assign out_position_o    = out_data.position;
  assign out_last_o        = out_data.last;

  `ASSERT_SAME(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= CW'(DEPTH), "fill count beyond depth")
  `ASSERT_SAME(a_no_rw_clash, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
  `ASSERT_NEXT(a_full_drop, clk_i, rst_ni, in_acc && (in_kind_i == sil_pkg::KIND_INSERT) && full, (state_q == sil_pkg::ST_RESP) && (resp_status_q == sil_pkg::STAT_DROPPED), "insert into full table not dropped")
  `ASSERT_NEXT(a_last_idle, clk_i, rst_ni, push && push_data.last, state_q == sil_pkg::ST_IDLE, "final word not followed by idle")

endmodule

@@ verif/sorted_insert_list_unit_test.sv @@
// ---------------------------------------------------------------------------
// sorted_insert_list_unit_test
// Self-checking bench for the sorted insert list unit. A short table of
// directed words covers the empty, full and cleared cases, then randomised
// fill / readout / clear runs follow. Each result word is checked against a
// local copy of the ordered table, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module sorted_insert_list_unit_test;

  localparam int Depth       = sil_pkg::DepthDefault;
  localparam int KindW       = sil_pkg::KindW;
  localparam int ValW        = sil_pkg::ValW;
  localparam int StatusW     = sil_pkg::StatusW;
  localparam int PosW        = sil_pkg::PosW;
  localparam int RandWords   = 436;
  localparam int QuietTail   = 60;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 24;

  // kind code the unit ignores
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ValW-1:0]  value;
    logic             typed;
    sil_pkg::status_e status;
    logic [PosW-1:0]  position;
  } row_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_stall_o;
  logic [KindW-1:0]    in_kind_i         = '0;
  logic [ValW-1:0]     in_value_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i       = 1'b0;
  logic [StatusW-1:0]  out_status_o;
  logic [ValW-1:0]     out_entry_value_o;
  logic [PosW-1:0]     out_position_o;
  logic                out_last_o;

  // local copy of the table
  logic [ValW-1:0] table_mem [Depth];
  int              fill_level = 0;

  sil_pkg::result_t fresh_results [$];
  sil_pkg::result_t due_results [$];
  row_t             directed_rows [$];

  int  cycles       = 0;
  int  failures     = 0;
  int  words_in     = 0;
  int  seen_results = 0;
  int  drops        = 0;
  int  clears       = 0;
  int  peak_fill    = 0;
  int  stall_left   = 0;
  bit  quiet        = 1'b0;

  sorted_insert_list_unit #(.DEPTH(Depth)) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_kind_i         (in_kind_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_status_o      (out_status_o),
    .out_entry_value_o (out_entry_value_o),
    .out_position_o    (out_position_o),
    .out_last_o        (out_last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sorted_insert_list_unit_test failed");
      $finish;
    end
  end

  function automatic bit calm_spell();
    return (cycles % 1024) >= 768;
  endfunction

  function automatic sil_pkg::result_t make_result(sil_pkg::status_e st,
                                                   logic [ValW-1:0] v,
                                                   logic [PosW-1:0] pos, logic lst);
    sil_pkg::result_t r;
    r.status      = st;
    r.entry_value = v;
    r.position    = pos;
    r.last        = lst;
    return r;
  endfunction

  // Work out what one word does to the table and which results it gives.
  function automatic void apply_to_table(logic [KindW-1:0] k, logic [ValW-1:0] v);
    int slot;
    fresh_results.delete();
    if (k == sil_pkg::KIND_INSERT) begin
      if (fill_level >= Depth) begin
        drops++;
        fresh_results.push_back(make_result(sil_pkg::STAT_DROPPED, '0, '0, 1'b1));
      end else begin
        slot = fill_level;
        // head stays put; find first smaller entry behind it
        for (int i = 1; i < fill_level; i++) begin
          if (table_mem[i] < v) begin
            slot = i;
            break;
          end
        end
        for (int i = fill_level; i > slot; i--) table_mem[i] = table_mem[i-1];
        table_mem[slot] = v;
        fill_level++;
        if (fill_level > peak_fill) peak_fill = fill_level;
        fresh_results.push_back(make_result(sil_pkg::STAT_INSERTED, '0, slot[PosW-1:0],
                                            1'b1));
      end
    end else if (k == sil_pkg::KIND_READOUT) begin
      if (fill_level == 0)
        fresh_results.push_back(make_result(sil_pkg::STAT_EMPTY, '0, '0, 1'b1));
      for (int i = 0; i < fill_level; i++)
        fresh_results.push_back(make_result(sil_pkg::STAT_ENTRY, table_mem[i],
                                            i[PosW-1:0], i == fill_level - 1));
    end else if (k == sil_pkg::KIND_CLEAR) begin
      fill_level = 0;
      clears++;
      fresh_results.push_back(make_result(sil_pkg::STAT_CLEARED, '0, '0, 1'b1));
    end
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = ValW'($urandom_range(120, 123));  // clustered, so equal values show up
      default: v = ValW'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // Offer one word, hold it until taken, then book its results.
  task automatic send_word(input logic [KindW-1:0] k, input logic [ValW-1:0] v,
                           input logic typed = 1'b0,
                           input sil_pkg::status_e st = sil_pkg::STAT_INSERTED,
                           input logic [PosW-1:0] pos = '0);
    int gap;
    if (!quiet && !calm_spell() && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= k;
    in_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_to_table(k, v);
    if (typed) due_results.push_back(make_result(st, '0, pos, 1'b1));
    else foreach (fresh_results[i]) due_results.push_back(fresh_results[i]);
    if (k != KindUnused) words_in++;
  endtask

  task automatic add_row(input logic [KindW-1:0] k, input logic [ValW-1:0] v,
                         input logic typed = 1'b0,
                         input sil_pkg::status_e st = sil_pkg::STAT_INSERTED,
                         input logic [PosW-1:0] pos = '0);
    row_t r;
    r.kind     = k;
    r.value    = v;
    r.typed    = typed;
    r.status   = st;
    r.position = pos;
    directed_rows.push_back(r);
  endtask

  // Receiver stalls in bursts of random length.
  always @(posedge clk_i) begin
    if (!rst_ni || quiet || calm_spell()) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    sil_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_results++;
      if (due_results.size() == 0) begin
        $error("unexpected result word: status %0d value %0d position %0d",
               out_status_o, out_entry_value_o, out_position_o);
        failures++;
      end else begin
        want = due_results.pop_front();
        if (out_status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status_o);
          failures++;
        end
        if (out_entry_value_o !== want.entry_value) begin
          $error("entry_value: expected %0d, actual %0d", want.entry_value,
                 out_entry_value_o);
          failures++;
        end
        if (out_position_o !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_position_o);
          failures++;
        end
        if (out_last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last_o);
          failures++;
        end
      end
    end
  end

  initial begin
    int  run_len;
    bit  paused;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(sil_pkg::KIND_READOUT, 8'h00, 1'b1, sil_pkg::STAT_EMPTY);
    add_row(KindUnused,            8'hFF);
    add_row(sil_pkg::KIND_INSERT,  8'h80, 1'b1, sil_pkg::STAT_INSERTED, 4'd0);
    add_row(sil_pkg::KIND_INSERT,  8'h00);
    add_row(sil_pkg::KIND_INSERT,  8'hFF);
    add_row(sil_pkg::KIND_INSERT,  8'hFF);
    add_row(sil_pkg::KIND_READOUT, 8'hFF);
    add_row(sil_pkg::KIND_INSERT,  8'h7F);
    add_row(sil_pkg::KIND_INSERT,  8'h01);
    add_row(sil_pkg::KIND_INSERT,  8'hFE);
    add_row(sil_pkg::KIND_INSERT,  8'h55);
    add_row(sil_pkg::KIND_INSERT,  8'hAA);
    add_row(sil_pkg::KIND_INSERT,  8'h80);
    add_row(sil_pkg::KIND_INSERT,  8'h00);
    add_row(sil_pkg::KIND_INSERT,  8'h81);
    add_row(sil_pkg::KIND_INSERT,  8'h7F);
    add_row(sil_pkg::KIND_INSERT,  8'h33);
    add_row(sil_pkg::KIND_INSERT,  8'hCC);
    add_row(sil_pkg::KIND_INSERT,  8'h02);
    add_row(sil_pkg::KIND_INSERT,  8'hFF, 1'b1, sil_pkg::STAT_DROPPED);
    add_row(sil_pkg::KIND_READOUT, 8'h00);
    add_row(sil_pkg::KIND_CLEAR,   8'hA5, 1'b1, sil_pkg::STAT_CLEARED);
    add_row(sil_pkg::KIND_READOUT, 8'h5A, 1'b1, sil_pkg::STAT_EMPTY);
    add_row(sil_pkg::KIND_INSERT,  8'h00, 1'b1, sil_pkg::STAT_INSERTED, 4'd0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].status, directed_rows[i].position);

    // random fill runs, each closed by a readout and usually a clear
    while (words_in < directed_rows.size() - 1 + RandWords) begin
      run_len = $urandom_range(0, 19);
      for (int j = 0; j < run_len; j++) begin
        if ($urandom_range(0, 5) == 0) send_word(sil_pkg::KIND_READOUT, pick_value());
        if ($urandom_range(0, 24) == 0) send_word(KindUnused, pick_value());
        send_word(sil_pkg::KIND_INSERT, pick_value());
      end
      send_word(sil_pkg::KIND_READOUT, pick_value());
      if ($urandom_range(0, 3) != 0) send_word(sil_pkg::KIND_CLEAR, pick_value());
      if (!paused && words_in > RandWords / 2) begin
        // hold off until the unit has drained
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (due_results.size() != 0) @(posedge clk_i);
      end
      if (words_in > directed_rows.size() + RandWords - QuietTail) quiet = 1'b1;
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words (%0d clears, %0d inserts dropped on a full table),",
             words_in, clears, drops);
    $display("checked %0d result words; table filled to at most %0d entries.",
             seen_results, peak_fill);
    if (failures == 0) begin
      $display("sorted_insert_list_unit_test passed");
    end else begin
      $display("sorted_insert_list_unit_test failed");
    end
    $finish;
  end

endmodule
